FILE: hw/rtl/qte_pkg.sv
// qte_pkg: widths, angle constants, CORDIC arctangent table and sideband types
// for the quaternion to euler angles unit; no dependencies
`default_nettype none
package qte_pkg;

	localparam int VW       = 35;
	localparam int CW       = 34;
	localparam int POS_W    = 6;
	localparam int FIT_POS  = 29;
	localparam int ATAN_LEN = 24;

	localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;

	localparam logic [31:0] ANG_ZERO     = 32'h0000_0000;
	localparam logic [31:0] ANG_PI       = 32'h8000_0000;
	localparam logic [31:0] ANG_HALF_PI  = 32'h4000_0000;
	localparam logic [31:0] ANG_NHALF_PI = 32'hC000_0000;

	localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	function automatic logic [31:0] atan_entry(input int i);
		if (i < ATAN_LEN) begin
			return ATAN_TAB[i];
		end
		return '0;
	endfunction

	typedef struct packed {
		logic              zero;
		logic signed [CW-1:0] p2;
		logic              roll_spec;
		logic [31:0]       roll_sa;
		logic              yaw_spec;
		logic [31:0]       yaw_sa;
	} side_a_t;

	typedef struct packed {
		logic        zero;
		logic [15:0] roll;
		logic [15:0] yaw;
		logic        pitch_spec;
		logic [31:0] pitch_sa;
	} side_b_t;

endpackage
`default_nettype wire

FILE: hw/rtl/qte_cordic.sv
// qte_cordic: pipelined vectoring CORDIC, one stage per iteration plus a
// quadrant pre-rotation stage; uses qte_pkg for widths and the arctangent table
`default_nettype none
module qte_cordic
	import qte_pkg::*;
#(
	parameter int STAGES = 16,
	parameter int SW     = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic signed [CW-1:0] in_x,
	input  wire logic signed [CW-1:0] in_y,
	input  wire logic [SW-1:0]        in_side,
	output logic                      out_valid,
	output logic signed [CW-1:0]      out_mag,
	output logic [31:0]               out_ang,
	output logic [SW-1:0]             out_side
);

	logic                 vld_s  [STAGES+1];
	logic signed [CW-1:0] x_s    [STAGES+1];
	logic signed [CW-1:0] y_s    [STAGES+1];
	logic [31:0]          z_s    [STAGES+1];
	logic [SW-1:0]        side_s [STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			if (in_x[CW-1]) begin
				x_s[0] <= -in_x;
				y_s[0] <= -in_y;
				z_s[0] <= ANG_PI;
			end else begin
				x_s[0] <= in_x;
				y_s[0] <= in_y;
				z_s[0] <= ANG_ZERO;
			end
		end
	end

	for (genvar i = 1; i <= STAGES; i++) begin : g_stage
		localparam logic [31:0] A = atan_entry(i - 1);
		logic signed [CW-1:0] dx, dy;
		assign dx = y_s[i-1] >>> (i - 1);
		assign dy = x_s[i-1] >>> (i - 1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= side_s[i-1];
				if (!y_s[i-1][CW-1]) begin
					x_s[i] <= x_s[i-1] + dx;
					y_s[i] <= y_s[i-1] - dy;
					z_s[i] <= z_s[i-1] + A;
				end else begin
					x_s[i] <= x_s[i-1] - dx;
					y_s[i] <= y_s[i-1] + dy;
					z_s[i] <= z_s[i-1] - A;
				end
			end
		end
	end

	assign out_valid = vld_s[STAGES];
	assign out_mag   = x_s[STAGES];
	assign out_ang   = z_s[STAGES];
	assign out_side  = side_s[STAGES];

endmodule
`default_nettype wire

FILE: hw/rtl/quaternion_to_euler_angles_unit.sv
// quaternion_to_euler_angles_unit: quaternion in, zyx euler binary angles out
// depends on qte_pkg and qte_cordic
//
// channel  dir  width  contents
// s_       in   64     tdata: quat_x, quat_y, quat_z, quat_w
// m_       out  48+1   tdata: roll_angle, pitch_angle, yaw_angle; tuser: zero_norm
//
// one quaternion accepted per cycle while the output queue is not full; the path runs through
// two chained cordic pipelines plus product, range fit and rounding stages
// a two-entry output queue decouples the pipeline; it stalls only when full
// arst_n clears valid bits and the queue; payload registers are not reset
`default_nettype none
module quaternion_to_euler_angles_unit
	import qte_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // roll_angle, pitch_angle, yaw_angle
	output logic             m_tuser    // zero_norm
);

	localparam int SA_W = $bits(side_a_t);
	localparam int SB_W = $bits(side_b_t);

	function automatic logic [CW-1:0] mag_of(input logic signed [VW-1:0] v);
		logic signed [VW-1:0] n;
		n = v[VW-1] ? -v : v;
		return n[CW-1:0];
	endfunction

	function automatic logic [POS_W-1:0] msb_pos(input logic [CW-1:0] v);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = 0; i < CW; i++) begin
			if (v[i]) p = POS_W'(i);
		end
		return p;
	endfunction

	function automatic logic signed [CW-1:0] fit(input logic signed [VW-1:0] v,
			input logic [POS_W-1:0] p);
		logic signed [VW-1:0] r;
		if (p > POS_W'(FIT_POS)) begin
			r = v >>> (p - POS_W'(FIT_POS));
		end else begin
			r = v <<< (POS_W'(FIT_POS) - p);
		end
		return r[CW-1:0];
	endfunction

	logic en;
	logic [1:0] cnt_q;
	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;

	// stage 1: products
	logic signed [15:0] qx, qy, qz, qw;
	assign qx = s_tdata[15:0];
	assign qy = s_tdata[31:16];
	assign qz = s_tdata[47:32];
	assign qw = s_tdata[63:48];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic zero_s1, zero_s2, zero_s3, zero_s4, zero_s5;
	logic signed [31:0] pwx_s1, pyz_s1, pwz_s1, pxy_s1, pwy_s1, pxz_s1;
	logic signed [31:0] pww_s1, pxx_s1, pyy_s1, pzz_s1;
	logic signed [VW-1:0] rn_s2, rd_s2, yn_s2, yd_s2, sp_s2;
	logic signed [VW-1:0] rn_s3, rd_s3, yn_s3, yd_s3, sp_s3;
	logic signed [VW-1:0] rn_s4, rd_s4, yn_s4, yd_s4, sp_s4;
	logic [CW-1:0] orr_s3, ory_s3, orp_s3;
	logic [POS_W-1:0] posr_s4, posy_s4, posp_s4;
	logic rspec_s3, yspec_s3, rspec_s4, yspec_s4, rspec_s5, yspec_s5;
	logic [31:0] rsa_s3, ysa_s3, rsa_s4, ysa_s4, rsa_s5, ysa_s5;
	logic signed [CW-1:0] rx_s5, ry_s5, yx_s5, yy_s5, tx_s5, ty_s5, tp_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= (s_tdata == 64'd0);
			pwx_s1 <= qw * qx;
			pyz_s1 <= qy * qz;
			pwz_s1 <= qw * qz;
			pxy_s1 <= qx * qy;
			pwy_s1 <= qw * qy;
			pxz_s1 <= qx * qz;
			pww_s1 <= qw * qw;
			pxx_s1 <= qx * qx;
			pyy_s1 <= qy * qy;
			pzz_s1 <= qz * qz;

			zero_s2 <= zero_s1;
			rn_s2 <= (VW'(pwx_s1) + VW'(pyz_s1)) <<< 1;
			rd_s2 <= VW'(pww_s1) - VW'(pxx_s1) - VW'(pyy_s1) + VW'(pzz_s1);
			yn_s2 <= (VW'(pwz_s1) + VW'(pxy_s1)) <<< 1;
			yd_s2 <= VW'(pww_s1) + VW'(pxx_s1) - VW'(pyy_s1) - VW'(pzz_s1);
			sp_s2 <= (VW'(pwy_s1) - VW'(pxz_s1)) <<< 1;

			zero_s3 <= zero_s2;
			rn_s3 <= rn_s2;
			rd_s3 <= rd_s2;
			yn_s3 <= yn_s2;
			yd_s3 <= yd_s2;
			sp_s3 <= sp_s2;
			orr_s3 <= mag_of(rn_s2) | mag_of(rd_s2);
			ory_s3 <= mag_of(yn_s2) | mag_of(yd_s2);
			orp_s3 <= mag_of(rn_s2) | mag_of(rd_s2) | mag_of(sp_s2);
			rspec_s3 <= (rn_s2 == '0) || (rd_s2 == '0);
			if (rn_s2 == '0) rsa_s3 <= rd_s2[VW-1] ? ANG_PI : ANG_ZERO;
			else             rsa_s3 <= rn_s2[VW-1] ? ANG_NHALF_PI : ANG_HALF_PI;
			yspec_s3 <= (yn_s2 == '0) || (yd_s2 == '0);
			if (yn_s2 == '0) ysa_s3 <= yd_s2[VW-1] ? ANG_PI : ANG_ZERO;
			else             ysa_s3 <= yn_s2[VW-1] ? ANG_NHALF_PI : ANG_HALF_PI;

			zero_s4 <= zero_s3;
			rn_s4 <= rn_s3;
			rd_s4 <= rd_s3;
			yn_s4 <= yn_s3;
			yd_s4 <= yd_s3;
			sp_s4 <= sp_s3;
			posr_s4 <= msb_pos(orr_s3);
			posy_s4 <= msb_pos(ory_s3);
			posp_s4 <= msb_pos(orp_s3);
			rspec_s4 <= rspec_s3;
			rsa_s4 <= rsa_s3;
			yspec_s4 <= yspec_s3;
			ysa_s4 <= ysa_s3;

			zero_s5 <= zero_s4;
			rx_s5 <= fit(rd_s4, posr_s4);
			ry_s5 <= fit(rn_s4, posr_s4);
			yx_s5 <= fit(yd_s4, posy_s4);
			yy_s5 <= fit(yn_s4, posy_s4);
			tx_s5 <= fit(rd_s4, posp_s4);
			ty_s5 <= fit(rn_s4, posp_s4);
			tp_s5 <= fit(sp_s4, posp_s4);
			rspec_s5 <= rspec_s4;
			rsa_s5 <= rsa_s4;
			yspec_s5 <= yspec_s4;
			ysa_s5 <= ysa_s4;
		end
	end

	// first cordic bank
	side_a_t sa_in, sa_out;
	logic va;
	logic signed [CW-1:0] pmag_a;
	logic [31:0] rang_a, yang_a;

	assign sa_in = '{zero: zero_s5, p2: tp_s5, roll_spec: rspec_s5, roll_sa: rsa_s5,
		yaw_spec: yspec_s5, yaw_sa: ysa_s5};

	qte_cordic #(.STAGES(CORDIC_STAGES), .SW(SA_W)) u_cordic_pm (
		.clk, .arst_n, .en,
		.in_valid(vld_s5), .in_x(tx_s5), .in_y(ty_s5), .in_side(sa_in),
		.out_valid(va), .out_mag(pmag_a), .out_ang(), .out_side(sa_out)
	);

	qte_cordic #(.STAGES(CORDIC_STAGES), .SW(1)) u_cordic_roll (
		.clk, .arst_n, .en,
		.in_valid(vld_s5), .in_x(rx_s5), .in_y(ry_s5), .in_side(1'b0),
		.out_valid(), .out_mag(), .out_ang(rang_a), .out_side()
	);

	qte_cordic #(.STAGES(CORDIC_STAGES), .SW(1)) u_cordic_yaw (
		.clk, .arst_n, .en,
		.in_valid(vld_s5), .in_x(yx_s5), .in_y(yy_s5), .in_side(1'b0),
		.out_valid(), .out_mag(), .out_ang(yang_a), .out_side()
	);

	// pitch sine scaling and second range fit
	logic [31:0] rfull, yfull, rrnd, yrnd;
	assign rfull = sa_out.roll_spec ? sa_out.roll_sa : rang_a;
	assign yfull = sa_out.yaw_spec ? sa_out.yaw_sa : yang_a;
	assign rrnd  = rfull + 32'h0000_8000;
	assign yrnd  = yfull + 32'h0000_8000;

	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic zero_s6, zero_s7, zero_s8, zero_s9, zero_s10;
	logic [15:0] roll_s6, yaw_s6, roll_s7, yaw_s7, roll_s8, yaw_s8;
	logic [15:0] roll_s9, yaw_s9, roll_s10, yaw_s10;
	logic signed [62:0] prod_s6;
	logic signed [CW-1:0] mag_s6, mag_s7, mag_s8, mag_s9, sk_s7, sk_s8, sk_s9;
	logic [CW-1:0] orq_s8;
	logic [POS_W-1:0] posq_s9;
	logic pspec_s8, pspec_s9, pspec_s10;
	logic [31:0] psa_s8, psa_s9, psa_s10;
	logic signed [CW-1:0] bx_s10, by_s10;
	logic signed [30:0] p2n;
	logic signed [62:0] prod_sh;

	assign p2n     = sa_out.p2[30:0];
	assign prod_sh = prod_s6 >>> 30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s6  <= va;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s6 <= sa_out.zero;
			roll_s6 <= rrnd[31:16];
			yaw_s6  <= yrnd[31:16];
			mag_s6  <= pmag_a;
			prod_s6 <= p2n * GAIN_Q30;

			zero_s7 <= zero_s6;
			roll_s7 <= roll_s6;
			yaw_s7  <= yaw_s6;
			mag_s7  <= mag_s6;
			sk_s7   <= prod_sh[CW-1:0];

			zero_s8 <= zero_s7;
			roll_s8 <= roll_s7;
			yaw_s8  <= yaw_s7;
			mag_s8  <= mag_s7;
			sk_s8   <= sk_s7;
			orq_s8  <= mag_of(VW'(mag_s7)) | mag_of(VW'(sk_s7));
			pspec_s8 <= (sk_s7 == '0) || (mag_s7 == '0);
			if (sk_s7 == '0) psa_s8 <= mag_s7[CW-1] ? ANG_PI : ANG_ZERO;
			else             psa_s8 <= sk_s7[CW-1] ? ANG_NHALF_PI : ANG_HALF_PI;

			zero_s9 <= zero_s8;
			roll_s9 <= roll_s8;
			yaw_s9  <= yaw_s8;
			mag_s9  <= mag_s8;
			sk_s9   <= sk_s8;
			posq_s9 <= msb_pos(orq_s8);
			pspec_s9 <= pspec_s8;
			psa_s9  <= psa_s8;

			zero_s10 <= zero_s9;
			roll_s10 <= roll_s9;
			yaw_s10  <= yaw_s9;
			bx_s10   <= fit(VW'(mag_s9), posq_s9);
			by_s10   <= fit(VW'(sk_s9), posq_s9);
			pspec_s10 <= pspec_s9;
			psa_s10  <= psa_s9;
		end
	end

	// second cordic: pitch angle
	side_b_t sb_in, sb_out;
	logic vb;
	logic [31:0] pang_b;

	assign sb_in = '{zero: zero_s10, roll: roll_s10, yaw: yaw_s10,
		pitch_spec: pspec_s10, pitch_sa: psa_s10};

	qte_cordic #(.STAGES(CORDIC_STAGES), .SW(SB_W)) u_cordic_pitch (
		.clk, .arst_n, .en,
		.in_valid(vld_s10), .in_x(bx_s10), .in_y(by_s10), .in_side(sb_in),
		.out_valid(vb), .out_mag(), .out_ang(pang_b), .out_side(sb_out)
	);

	logic signed [32:0] pa_full, pa_rnd;
	logic signed [16:0] pa_sh;
	logic [15:0] pitch_c;
	assign pa_full = 33'(signed'(sb_out.pitch_spec ? sb_out.pitch_sa : pang_b));
	assign pa_rnd  = pa_full + 33'sh0_8000;
	assign pa_sh   = pa_rnd[32:16];

	always_comb begin
		if (pa_sh > 17'sd16384)       pitch_c = 16'd16384;
		else if (pa_sh < -17'sd16384) pitch_c = 16'hC000;
		else                          pitch_c = pa_sh[15:0];
	end

	// output stage: result register plus skid entry
	logic [48:0] res;
	logic [48:0] fifo_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic push, pop;

	assign res  = sb_out.zero ? {1'b1, 48'd0} : {1'b0, sb_out.yaw, pitch_c, sb_out.roll};
	assign push = en && vb;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= res;
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = fifo_q[rd_ptr_q][47:0];
	assign m_tuser  = fifo_q[rd_ptr_q][48];

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("output queue count overflow");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (cnt_q == 2'd2)) else $error("stall without full queue");
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 48'd0)) else $error("zero flag with angles");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");

endmodule
`default_nettype wire

FILE: tb/sv/quaternion_to_euler_angles_unit_test.sv
// quaternion_to_euler_angles_unit_test: stream testbench for the quaternion to euler unit
// compares every output transaction against a built-in bit-exact cordic predictor
// depends on qte_pkg and the quaternion_to_euler_angles_unit rtl
`default_nettype none
module quaternion_to_euler_angles_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import qte_pkg::*;

	localparam int STAGES = 16;
	localparam int LATENCY = 2 * STAGES + 13;
	localparam int N_RANDOM = 1630;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam longint K_GAIN = 64'sd1768195363;

	typedef struct packed {
		logic signed [15:0] yaw;
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
		logic               zero;
	} euler_t;

	typedef struct {
		logic signed [15:0] x, y, z, w;
		bit                 known;
		euler_t             angles;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;

	euler_t      expected_angles[$];
	int          mismatches;
	int          checked;
	int          idle_cycles;
	bit          calm;

	quaternion_to_euler_angles_unit #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint shr_floor(longint v, int s);
		if (s <= 0) return v;
		if (s >= 63) return v < 0 ? -64'sd1 : 64'sd0;
		return v >>> s;
	endfunction

	function automatic longint magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic void normalize3(inout longint a, inout longint b, inout longint c);
		longint m;
		int sh;
		m = magnitude(a);
		if (magnitude(b) > m) m = magnitude(b);
		if (magnitude(c) > m) m = magnitude(c);
		sh = 0;
		if (m == 0) return;
		while (m >= (64'sd1 << 30)) begin
			m = m >>> 1;
			sh++;
		end
		while (m < (64'sd1 << 29)) begin
			m = m <<< 1;
			sh--;
		end
		if (sh > 0) begin
			a = shr_floor(a, sh);
			b = shr_floor(b, sh);
			c = shr_floor(c, sh);
		end else begin
			a = a * (64'sd1 << (-sh));
			b = b * (64'sd1 << (-sh));
			c = c * (64'sd1 << (-sh));
		end
	endfunction

	function automatic longint vector_rotate(longint xi, longint yi, output logic [31:0] ang);
		longint dx, dy;
		logic [31:0] a;
		ang = ANG_ZERO;
		if (xi < 0) begin
			xi = -xi;
			yi = -yi;
			ang = ANG_PI;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = shr_floor(yi, i);
			dy = shr_floor(xi, i);
			a = i < ATAN_LEN ? ATAN_TAB[i] : 32'd0;
			if (yi >= 0) begin
				xi += dx;
				yi -= dy;
				ang += a;
			end else begin
				xi -= dx;
				yi += dy;
				ang -= a;
			end
		end
		return xi;
	endfunction

	function automatic logic [31:0] binary_atan2(longint yv, longint xv);
		logic [31:0] ang;
		longint unused;
		if (yv == 0) return xv >= 0 ? ANG_ZERO : ANG_PI;
		if (xv == 0) return yv > 0 ? ANG_HALF_PI : ANG_NHALF_PI;
		unused = 0;
		normalize3(xv, yv, unused);
		void'(vector_rotate(xv, yv, ang));
		return ang;
	endfunction

	function automatic logic [15:0] round_angle(logic [31:0] a);
		logic [31:0] t;
		t = a + 32'h8000;
		return t[31:16];
	endfunction

	function automatic euler_t predict_euler(logic signed [15:0] qx, logic signed [15:0] qy,
			logic signed [15:0] qz, logic signed [15:0] qw);
		longint x, y, z, w, rn, rd, yn, yd, s, pc, pn, ps, mag, sk, pa;
		logic [31:0] ang;
		euler_t r;
		x = qx;
		y = qy;
		z = qz;
		w = qw;
		r = '0;
		if (x == 0 && y == 0 && z == 0 && w == 0) begin
			r.zero = 1'b1;
			return r;
		end
		rn = 2 * (w * x + y * z);
		rd = w * w - x * x - y * y + z * z;
		yn = 2 * (w * z + x * y);
		yd = w * w + x * x - y * y - z * z;
		s  = 2 * (w * y - x * z);
		r.roll = round_angle(binary_atan2(rn, rd));
		r.yaw = round_angle(binary_atan2(yn, yd));
		pc = rd;
		pn = rn;
		ps = s;
		normalize3(pc, pn, ps);
		mag = vector_rotate(pc, pn, ang);
		sk = shr_floor(ps * K_GAIN, 30);
		ang = binary_atan2(sk, mag);
		pa = longint'(signed'(ang));
		pa = shr_floor(pa + 64'sd32768, 16);
		if (pa > 16384) pa = 16384;
		if (pa < -16384) pa = -16384;
		r.pitch = pa[15:0];
		return r;
	endfunction

	task automatic send_quaternion(logic signed [15:0] qx, logic signed [15:0] qy,
			logic signed [15:0] qz, logic signed [15:0] qw, bit known, euler_t typed);
		int gap;
		euler_t p;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		p = predict_euler(qx, qy, qz, qw);
		if (known && p !== typed) begin
			$display("table row disagrees with predictor: %h vs %h", typed, p);
			mismatches++;
		end
		s_tvalid <= 1'b1;
		s_tdata <= {qw, qz, qy, qx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_angles.push_back(p);
	endtask

	// output side: random stalls and transaction check
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				euler_t got, want;
				got = {m_tdata[47:32], m_tdata[31:16], m_tdata[15:0], m_tuser};
				checked++;
				if (expected_angles.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected transaction %h", got);
				end else begin
					want = expected_angles.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch #%0d: roll exp %0d got %0d, pitch exp %0d got %0d, yaw exp %0d got %0d, zero exp %0b got %0b",
								checked, want.roll, got.roll, want.pitch, got.pitch,
								want.yaw, got.yaw, want.zero, got.zero);
					end
				end
			end
			if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d transactions outstanding",
					expected_angles.size());
				$display("FAIL quaternion_to_euler_angles_unit");
				$finish;
			end
		end
	end

	stim_row_t directed[$];

	function automatic stim_row_t row(int x, int y, int z, int w, bit known = 0,
			int r = 0, int p = 0, int yw = 0, bit zf = 0);
		stim_row_t t;
		t.x = 16'(x);
		t.y = 16'(y);
		t.z = 16'(z);
		t.w = 16'(w);
		t.known = known;
		t.angles = '{yaw: 16'(yw), pitch: 16'(p), roll: 16'(r), zero: zf};
		return t;
	endfunction

	initial begin
		logic signed [15:0] rx, ry, rz, rw;
		int sel;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatches = 0;
		checked = 0;
		calm = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(row(0, 0, 0, 0, 1, 0, 0, 0, 1));
		directed.push_back(row(0, 0, 0, 16384, 1, 0, 0, 0, 0));
		directed.push_back(row(0, 0, 0, -16384, 1, 0, 0, 0, 0));
		directed.push_back(row(16384, 0, 0, 0, 1, -32768, 0, 0, 0));
		directed.push_back(row(0, 16384, 0, 0, 1, -32768, 0, -32768, 0));
		directed.push_back(row(0, 0, 16384, 0, 1, 0, 0, -32768, 0));
		directed.push_back(row(0, 11585, 0, 11585));
		directed.push_back(row(0, -11585, 0, 11585));
		directed.push_back(row(11585, 0, 0, 11585));
		directed.push_back(row(0, 0, 11585, 11585));
		directed.push_back(row(0, 0, -11585, 11585));
		directed.push_back(row(32767, 32767, 32767, 32767));
		directed.push_back(row(-32768, -32768, -32768, -32768));
		directed.push_back(row(-32768, 32767, -32768, 32767));
		directed.push_back(row(32767, -32768, 32767, -32768));
		directed.push_back(row(1, 0, 0, 0));
		directed.push_back(row(0, 0, 0, -1));
		directed.push_back(row(1, 1, 1, 1));
		directed.push_back(row(-1, 1, -1, 1));
		directed.push_back(row(8192, 8192, -8192, 8192));
		directed.push_back(row(1000, 16000, -1000, 16000));
		directed.push_back(row(-32768, 0, 0, 0));
		foreach (directed[i])
			send_quaternion(directed[i].x, directed[i].y, directed[i].z, directed[i].w,
				directed[i].known, directed[i].angles);

		// drain fully before the random part
		s_tvalid <= 1'b0;
		while (expected_angles.size() != 0) @(posedge clk);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - 200) calm = 1;
			sel = $urandom_range(0, 9);
			rx = 16'($urandom);
			ry = 16'($urandom);
			rz = 16'($urandom);
			rw = 16'($urandom);
			if (sel < 4) begin
				// unit-ish quaternions in q2.14
				rx = $signed(rx) >>> 2;
				ry = $signed(ry) >>> 2;
				rz = $signed(rz) >>> 2;
				rw = $signed(rw) >>> 2;
			end else if (sel == 4) begin
				// gimbal lock: y=w and z=-x
				ry = rw;
				rz = -rx;
			end else if (sel == 5) begin
				rx = $signed(rx) >>> $urandom_range(0, 15);
				ry = $signed(ry) >>> $urandom_range(0, 15);
				rz = $signed(rz) >>> $urandom_range(0, 15);
				rw = $signed(rw) >>> $urandom_range(0, 15);
			end else if (sel == 6) begin
				case ($urandom_range(0, 3))
					0: rx = '0;
					1: ry = '0;
					2: rz = '0;
					default: rw = '0;
				endcase
			end
			send_quaternion(rx, ry, rz, rw, 0, '0);
		end
		s_tvalid <= 1'b0;

		while (expected_angles.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("covered %0d quaternions: zero, axis, gimbal-lock, extreme and random",
			checked);
		if (mismatches == 0) begin
			$display("PASS quaternion_to_euler_angles_unit");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL quaternion_to_euler_angles_unit");
		end
		$finish;
	end

endmodule
`default_nettype wire
